>>> hdl/tgfam_pkg.sv
`timescale 1ns / 1ps
package tgfam_pkg;

  localparam int unsigned SampleBits   = 24;
  localparam int unsigned FractionBits = 15;
  localparam int unsigned RangeBits    = 24;
  localparam int unsigned DzBits       = 15;
  localparam int unsigned CfgIdxBits   = 1;
  localparam int unsigned CfgDataBits  = 24;

  // Deviations, sums and the product 866*(dc-db) fit comfortably in 48 bits.
  localparam int unsigned DevBits  = SampleBits + 1;
  localparam int unsigned NumBits  = 48;
  localparam int unsigned QBits    = FractionBits + 1;
  localparam int unsigned SqBits   = 2 * QBits + 1;
  localparam int unsigned DivBits  = 64;
  localparam int unsigned DivCntBits = 7;

  localparam logic [CfgIdxBits-1:0] RegFullRange = 1'd0;
  localparam logic [CfgIdxBits-1:0] RegDeadzone  = 1'd1;

  localparam logic [RangeBits-1:0] FullRangeReset = 24'd65536;
  localparam logic [DzBits-1:0]    DeadzoneReset  = 15'd1638;

  typedef struct packed {
    logic signed [SampleBits-1:0] gauge_a_sample;
    logic signed [SampleBits-1:0] gauge_b_sample;
    logic signed [SampleBits-1:0] gauge_c_sample;
    logic signed [SampleBits-1:0] gauge_a_baseline;
    logic signed [SampleBits-1:0] gauge_b_baseline;
    logic signed [SampleBits-1:0] gauge_c_baseline;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic signed [15:0] raw_a_scaled;
    logic signed [15:0] raw_b_scaled;
    logic signed [15:0] raw_c_scaled;
  } out_beat_t;

  // Classified work item handed from the front end to the back end.
  typedef struct packed {
    logic signed [DevBits-1:0] da;
    logic signed [DevBits-1:0] db;
    logic signed [DevBits-1:0] dc;
    logic signed [NumBits-1:0] nx;
    logic signed [NumBits-1:0] ny;
    logic signed [NumBits-1:0] nz;
  } work_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV_X, ST_DIV_Y, ST_DIV_Z, ST_SQRT, ST_FACTOR,
    ST_NX, ST_NY, ST_RAW_A, ST_RAW_B, ST_RAW_C, ST_DONE
  } back_state_e;

  typedef struct packed {
    logic                start;
    logic [DivBits-1:0]  num;
    logic [DivBits-1:0]  den;
  } div_req_t;

endpackage

>>> hdl/tgfam_front.sv
`timescale 1ns / 1ps
module tgfam_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid,
  output logic                in_ready,
  input  tgfam_pkg::in_beat_t in_data_i,
  output logic                q_valid_o,
  input  logic                q_ready_i,
  output tgfam_pkg::work_t    q_data_o
);

  localparam int unsigned Depth = 2;

  tgfam_pkg::work_t     item;
  tgfam_pkg::work_t     mem_q [Depth];
  logic                 wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0]           cnt_q, cnt_d;
  logic                 push, pop;

  // Deviations and the three axis numerators.
  always_comb begin
    item.da = tgfam_pkg::DevBits'(in_data_i.gauge_a_sample)
            - tgfam_pkg::DevBits'(in_data_i.gauge_a_baseline);
    item.db = tgfam_pkg::DevBits'(in_data_i.gauge_b_sample)
            - tgfam_pkg::DevBits'(in_data_i.gauge_b_baseline);
    item.dc = tgfam_pkg::DevBits'(in_data_i.gauge_c_sample)
            - tgfam_pkg::DevBits'(in_data_i.gauge_c_baseline);
    item.nx = (tgfam_pkg::NumBits'(item.dc) - tgfam_pkg::NumBits'(item.db))
            * 48'sd866;
    item.ny = tgfam_pkg::NumBits'(item.db) + tgfam_pkg::NumBits'(item.dc)
            - (tgfam_pkg::NumBits'(item.da) <<< 1);
    item.nz = tgfam_pkg::NumBits'(item.da) + tgfam_pkg::NumBits'(item.db)
            + tgfam_pkg::NumBits'(item.dc);
  end

  assign in_ready  = (cnt_q != 2'd2);
  assign push      = in_valid && in_ready;
  assign q_valid_o = (cnt_q != 2'd0);
  assign pop       = q_valid_o && q_ready_i;
  assign q_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2) else $error("queue count out of range");
  a_full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !in_ready) else $error("full queue accepted");
  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> cnt_q == $past(cnt_q) + 2'd1) else $error("count slip");
`endif

endmodule

>>> hdl/tgfam_divider.sv
`timescale 1ns / 1ps
module tgfam_divider (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tgfam_pkg::div_req_t           req_i,
  output logic                          busy_o,
  output logic [tgfam_pkg::DivBits-1:0] quo_o
);

  localparam int unsigned W = tgfam_pkg::DivBits;

  logic [W-1:0]                      rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [tgfam_pkg::DivCntBits-1:0]  cnt_q, cnt_d;
  logic                              busy_q, busy_d;
  logic [W:0]                        trial;

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = '0;
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.num;
      den_d  = req_i.den;
      cnt_d  = tgfam_pkg::DivCntBits'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {rem_q, quo_q[W-1]} - {1'b0, den_q};
      if (!trial[W]) begin
        rem_d = trial[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[W-2:0], quo_q[W-1]};
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d  = cnt_q - 1'b1;
      busy_d = (cnt_q != 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

>>> hdl/tgfam_back.sv
`timescale 1ns / 1ps
module tgfam_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [tgfam_pkg::RangeBits-1:0]     full_range_i,
  input  logic [tgfam_pkg::DzBits-1:0]        deadzone_i,
  input  logic                                q_valid_i,
  output logic                                q_ready_o,
  input  tgfam_pkg::work_t                    q_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output tgfam_pkg::out_beat_t                out_data_o
);

  localparam int unsigned W  = tgfam_pkg::DivBits;
  localparam int unsigned QB = tgfam_pkg::QBits;
  localparam int unsigned PB = 2 * QB;
  localparam logic [W-1:0] QOne = W'(1) << tgfam_pkg::FractionBits;

  tgfam_pkg::back_state_e state_q, state_d;
  tgfam_pkg::work_t       w_q;
  tgfam_pkg::div_req_t    req;
  logic                   div_busy;
  logic [W-1:0]           div_quo;
  logic                   wait_q, wait_d;

  logic [W-1:0]  range_q;
  logic [QB-1:0] fx_q, fy_q, fz_q, len_q, fac_q, dz_q;
  logic          sx_q, sy_q, sz_q;
  logic signed [15:0] ra_q, rb_q, rc_q;

  // Integer square root, one result bit per cycle.
  logic [tgfam_pkg::SqBits-1:0] sq_v_q, sq_bit_q, sq_res_q;
  logic                         inside_q;

  tgfam_pkg::out_beat_t ob_q;
  logic                 ob_valid_q;

  tgfam_divider u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .busy_o(div_busy),
    .quo_o (div_quo)
  );

  function automatic logic [W-1:0] mag(input logic signed [tgfam_pkg::NumBits-1:0] v);
    logic [tgfam_pkg::NumBits-1:0] m;
    m = v[tgfam_pkg::NumBits-1] ? -v : v;
    return W'(m);
  endfunction

  function automatic logic signed [15:0] q15_out(input logic s, input logic [QB-1:0] v);
    logic [QB+15-1:0] p;
    logic [15:0]      r;
    p = (QB+15)'(v) * (QB+15)'(32767);
    r = 16'(p >> tgfam_pkg::FractionBits);
    return s ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [15:0] raw_sat(input logic s, input logic [W-1:0] r);
    logic signed [15:0] o;
    if (s) begin
      o = (r > 64'd32768) ? -16'sd32768 : -$signed(r[15:0]);
    end else begin
      o = (r > 64'd32767) ? 16'sd32767 : $signed(r[15:0]);
    end
    return o;
  endfunction

  logic          div_done;
  logic [W-1:0]  clamp_val;
  logic [W-1:0]  p_mag;

  assign div_done  = wait_q && !div_busy && !req.start;
  assign q_ready_o = (state_q == tgfam_pkg::ST_IDLE);

  // Ratio divide helper: clamp to one when the magnitude reaches the denominator.
  always_comb begin
    clamp_val = (div_quo > QOne) ? QOne : div_quo;
    p_mag     = '0;
    unique case (state_q)
      tgfam_pkg::ST_DIV_X: p_mag = mag(w_q.nx);
      tgfam_pkg::ST_DIV_Y: p_mag = mag(w_q.ny);
      default:             p_mag = mag(w_q.nz);
    endcase
  end

  always_comb begin
    state_d   = state_q;
    wait_d    = wait_q;
    req.start = 1'b0;
    req.num   = '0;
    req.den   = '0;
    unique case (state_q)
      tgfam_pkg::ST_IDLE: begin
        if (q_valid_i) state_d = tgfam_pkg::ST_DIV_X;
      end
      tgfam_pkg::ST_DIV_X, tgfam_pkg::ST_DIV_Y, tgfam_pkg::ST_DIV_Z: begin
        if (!wait_q) begin
          req.start = 1'b1;
          req.num   = p_mag << tgfam_pkg::FractionBits;
          req.den   = (state_q == tgfam_pkg::ST_DIV_X) ? range_q * 64'd1000 :
                      (state_q == tgfam_pkg::ST_DIV_Y) ? range_q << 1 :
                                                         range_q * 64'd3;
          wait_d    = 1'b1;
        end else if (div_done) begin
          wait_d  = 1'b0;
          state_d = (state_q == tgfam_pkg::ST_DIV_X) ? tgfam_pkg::ST_DIV_Y :
                    (state_q == tgfam_pkg::ST_DIV_Y) ? tgfam_pkg::ST_DIV_Z :
                                                       tgfam_pkg::ST_SQRT;
        end
      end
      tgfam_pkg::ST_SQRT: begin
        if (wait_q && sq_bit_q == '0) begin
          wait_d  = 1'b0;
          state_d = tgfam_pkg::ST_FACTOR;
        end else if (!wait_q) begin
          wait_d = 1'b1;
        end
      end
      tgfam_pkg::ST_FACTOR: begin
        if (inside_q) begin
          state_d = tgfam_pkg::ST_RAW_A;
        end else if (!wait_q) begin
          req.start = 1'b1;
          req.num   = W'(len_q - dz_q) << tgfam_pkg::FractionBits;
          req.den   = QOne - W'(dz_q);
          wait_d    = 1'b1;
        end else if (div_done) begin
          wait_d  = 1'b0;
          state_d = tgfam_pkg::ST_NX;
        end
      end
      tgfam_pkg::ST_NX, tgfam_pkg::ST_NY: begin
        if (!wait_q) begin
          req.start = 1'b1;
          req.num   = W'(PB'((state_q == tgfam_pkg::ST_NX) ? fx_q : fy_q) * PB'(fac_q));
          req.den   = W'(len_q);
          wait_d    = 1'b1;
        end else if (div_done) begin
          wait_d  = 1'b0;
          state_d = (state_q == tgfam_pkg::ST_NX) ? tgfam_pkg::ST_NY :
                                                    tgfam_pkg::ST_RAW_A;
        end
      end
      tgfam_pkg::ST_RAW_A, tgfam_pkg::ST_RAW_B, tgfam_pkg::ST_RAW_C: begin
        if (!wait_q) begin
          req.start = 1'b1;
          req.num   = (state_q == tgfam_pkg::ST_RAW_A) ?
                        mag(tgfam_pkg::NumBits'(w_q.da)) * 64'd32767 :
                      (state_q == tgfam_pkg::ST_RAW_B) ?
                        mag(tgfam_pkg::NumBits'(w_q.db)) * 64'd32767 :
                        mag(tgfam_pkg::NumBits'(w_q.dc)) * 64'd32767;
          req.den   = range_q;
          wait_d    = 1'b1;
        end else if (div_done) begin
          wait_d  = 1'b0;
          state_d = (state_q == tgfam_pkg::ST_RAW_A) ? tgfam_pkg::ST_RAW_B :
                    (state_q == tgfam_pkg::ST_RAW_B) ? tgfam_pkg::ST_RAW_C :
                                                       tgfam_pkg::ST_DONE;
        end
      end
      tgfam_pkg::ST_DONE: begin
        if (!ob_valid_q || out_ready_i) state_d = tgfam_pkg::ST_IDLE;
      end
      default: state_d = tgfam_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= tgfam_pkg::ST_IDLE;
      wait_q     <= 1'b0;
      ob_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      wait_q  <= wait_d;
      if (state_q == tgfam_pkg::ST_DONE && (!ob_valid_q || out_ready_i)) begin
        ob_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        ob_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == tgfam_pkg::ST_IDLE && q_valid_i) begin
      w_q     <= q_data_i;
      range_q <= (full_range_i == '0) ? W'(1) : W'(full_range_i);
      dz_q    <= QB'((W'(deadzone_i) << tgfam_pkg::FractionBits) >> 15);
      sx_q    <= q_data_i.nx[tgfam_pkg::NumBits-1];
      sy_q    <= q_data_i.ny[tgfam_pkg::NumBits-1];
      sz_q    <= q_data_i.nz[tgfam_pkg::NumBits-1];
    end
    if (div_done) begin
      unique case (state_q)
        tgfam_pkg::ST_DIV_X: fx_q <= QB'(clamp_val);
        tgfam_pkg::ST_DIV_Y: fy_q <= QB'(clamp_val);
        tgfam_pkg::ST_DIV_Z: fz_q <= QB'(clamp_val);
        tgfam_pkg::ST_FACTOR: fac_q <= QB'(clamp_val);
        tgfam_pkg::ST_NX:    fx_q <= QB'(div_quo);
        tgfam_pkg::ST_NY:    fy_q <= QB'(div_quo);
        tgfam_pkg::ST_RAW_A: ra_q <= raw_sat(w_q.da[tgfam_pkg::DevBits-1], div_quo);
        tgfam_pkg::ST_RAW_B: rb_q <= raw_sat(w_q.db[tgfam_pkg::DevBits-1], div_quo);
        default:             rc_q <= raw_sat(w_q.dc[tgfam_pkg::DevBits-1], div_quo);
      endcase
    end
    if (state_q == tgfam_pkg::ST_SQRT) begin
      if (!wait_q) begin
        sq_v_q   <= tgfam_pkg::SqBits'(fx_q) * tgfam_pkg::SqBits'(fx_q)
                  + tgfam_pkg::SqBits'(fy_q) * tgfam_pkg::SqBits'(fy_q);
        sq_bit_q <= tgfam_pkg::SqBits'(1) << (tgfam_pkg::SqBits - 1 - ((tgfam_pkg::SqBits - 1) % 2));
        sq_res_q <= '0;
      end else if (sq_bit_q != '0) begin
        if (sq_v_q >= sq_res_q + sq_bit_q) begin
          sq_v_q   <= sq_v_q - (sq_res_q + sq_bit_q);
          sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
        end else begin
          sq_res_q <= sq_res_q >> 1;
        end
        sq_bit_q <= sq_bit_q >> 2;
      end else begin
        len_q    <= QB'(sq_res_q);
        inside_q <= (QB'(sq_res_q) < dz_q) || (sq_res_q == '0);
      end
    end
    if (state_q == tgfam_pkg::ST_FACTOR && inside_q) begin
      fx_q <= '0;
      fy_q <= '0;
    end
    if (state_q == tgfam_pkg::ST_DONE && (!ob_valid_q || out_ready_i)) begin
      ob_q.axis_x       <= q15_out(sx_q, fx_q);
      ob_q.axis_y       <= q15_out(sy_q, fy_q);
      ob_q.axis_z       <= q15_out(sz_q, fz_q);
      ob_q.raw_a_scaled <= ra_q;
      ob_q.raw_b_scaled <= rb_q;
      ob_q.raw_c_scaled <= rc_q;
    end
  end

  assign out_valid_o = ob_valid_q;
  assign out_data_o  = ob_q;

`ifndef SYNTH
  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_ready_o |-> state_q == tgfam_pkg::ST_IDLE) else $error("took item while busy");
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tgfam_pkg::ST_FACTOR |-> W'(len_q) <= 64'd2 * QOne)
    else $error("length beyond bound");
  a_div_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.start |-> !div_busy) else $error("divider restarted while busy");
`endif

endmodule

>>> hdl/tri_gauge_force_axis_mapper.sv
`timescale 1ns / 1ps
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_ready   | in_data_i  (tgfam_pkg::in_beat_t)
// out     | output    | out_valid / out_ready | out_data_o (tgfam_pkg::out_beat_t)
// cfg     | input     | cfg_we_i (no wait)    | cfg_idx_i, cfg_data_i
//
// An item outside the deadzone passes through the back end in order: it is taken
// from the queue, runs nine divides on the shared 64-bit restoring divider
// (start, 64 steps, collect) and the square root, and loads the output register.
// Inside the deadzone the three rescale divides are skipped.
// The front end and a two-beat queue accept new beats while the back end works.
// Reset clears control state and loads full_range 65536 and deadzone 1638.
// Either side may stall at any time; the output register holds its beat, and a
// full output register holds the back end in its last state.
module tri_gauge_force_axis_mapper (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  tgfam_pkg::in_beat_t                   in_data_i,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output tgfam_pkg::out_beat_t                  out_data_o,
  input  logic                                  cfg_we_i,
  input  logic [tgfam_pkg::CfgIdxBits-1:0]      cfg_idx_i,
  input  logic [tgfam_pkg::CfgDataBits-1:0]     cfg_data_i
);

  logic [tgfam_pkg::RangeBits-1:0] full_range_q;
  logic [tgfam_pkg::DzBits-1:0]    deadzone_q;
  logic                            q_valid, q_ready;
  tgfam_pkg::work_t                q_data;

  // Configuration registers; the user writes only while idle, not enforced here.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_range_q <= tgfam_pkg::FullRangeReset;
      deadzone_q   <= tgfam_pkg::DeadzoneReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tgfam_pkg::RegFullRange: full_range_q <= cfg_data_i;
        default:                 deadzone_q   <= cfg_data_i[tgfam_pkg::DzBits-1:0];
      endcase
    end
  end

  tgfam_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data_i(in_data_i),
    .q_valid_o(q_valid),
    .q_ready_i(q_ready),
    .q_data_o (q_data)
  );

  tgfam_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .full_range_i(full_range_q),
    .deadzone_i  (deadzone_q),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_data_i    (q_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o)
  );

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// Scoreboard for the force axis mapper: holds the configuration copy and
// the queue of predicted output beats.
class axis_scoreboard;
  tgfam_pkg::out_beat_t pending_beats[$];
  int unsigned          mismatches;
  logic [23:0]          full_range = 24'd65536;
  logic [14:0]          deadzone   = 15'd1638;

  static function longint unsigned umag(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  // Signed ratio in Q15, magnitude clamped to one.
  static function longint ratio_q15(longint num, longint unsigned den);
    longint unsigned p;
    longint unsigned r;
    p = umag(num);
    r = (p >= den) ? 64'd32768 : (p * 64'd32768) / den;
    return (num < 0) ? -longint'(r) : longint'(r);
  endfunction

  static function longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v   = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  static function logic [15:0] to_q15_out(longint v);
    longint unsigned r;
    r = (umag(v) * 64'd32767) / 64'd32768;
    return (v < 0) ? 16'(-longint'(r)) : 16'(r);
  endfunction

  static function logic [15:0] raw_to_16(longint d, longint unsigned range);
    longint unsigned r;
    r = (umag(d) * 64'd32767) / range;
    if (d < 0) begin
      if (r > 32768) r = 32768;
      return 16'(-longint'(r));
    end
    if (r > 32767) r = 32767;
    return 16'(r);
  endfunction

  function void note_input(tgfam_pkg::in_beat_t beat);
    tgfam_pkg::out_beat_t exp_beat;
    longint unsigned range;
    longint unsigned ax;
    longint unsigned ay;
    longint unsigned len;
    longint unsigned dz;
    longint unsigned factor;
    longint da;
    longint db;
    longint dc;
    longint fx;
    longint fy;
    longint fz;
    range = (full_range == 0) ? 1 : longint'(full_range);
    da = longint'(beat.gauge_a_sample) - longint'(beat.gauge_a_baseline);
    db = longint'(beat.gauge_b_sample) - longint'(beat.gauge_b_baseline);
    dc = longint'(beat.gauge_c_sample) - longint'(beat.gauge_c_baseline);
    fx = ratio_q15((dc - db) * 866, range * 1000);
    fy = ratio_q15(db + dc - 2 * da, range * 2);
    fz = ratio_q15(da + db + dc, range * 3);
    ax = umag(fx);
    ay = umag(fy);
    len = int_sqrt(ax * ax + ay * ay);
    dz = longint'(deadzone);
    // Inside the deadzone, or a zero vector, the planar axes go to zero.
    if (len < dz || len == 0) begin
      fx = 0;
      fy = 0;
    end else begin
      factor = ((len - dz) * 64'd32768) / (64'd32768 - dz);
      if (factor > 32768) factor = 32768;
      fx = (fx < 0) ? -longint'((ax * factor) / len) : longint'((ax * factor) / len);
      fy = (fy < 0) ? -longint'((ay * factor) / len) : longint'((ay * factor) / len);
    end
    exp_beat.axis_x       = to_q15_out(fx);
    exp_beat.axis_y       = to_q15_out(fy);
    exp_beat.axis_z       = to_q15_out(fz);
    exp_beat.raw_a_scaled = raw_to_16(da, range);
    exp_beat.raw_b_scaled = raw_to_16(db, range);
    exp_beat.raw_c_scaled = raw_to_16(dc, range);
    pending_beats.push_back(exp_beat);
  endfunction

  task automatic report(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %0d expected %0d", what, $signed(got), $signed(want));
    mismatches++;
  endtask

  task automatic check_result(tgfam_pkg::out_beat_t got);
    tgfam_pkg::out_beat_t want;
    if (pending_beats.size() == 0) begin
      report("unexpected beat, axis_x", got.axis_x, 16'd0);
      return;
    end
    want = pending_beats.pop_front();
    if (got.axis_x !== want.axis_x) report("axis_x", got.axis_x, want.axis_x);
    if (got.axis_y !== want.axis_y) report("axis_y", got.axis_y, want.axis_y);
    if (got.axis_z !== want.axis_z) report("axis_z", got.axis_z, want.axis_z);
    if (got.raw_a_scaled !== want.raw_a_scaled)
      report("raw_a_scaled", got.raw_a_scaled, want.raw_a_scaled);
    if (got.raw_b_scaled !== want.raw_b_scaled)
      report("raw_b_scaled", got.raw_b_scaled, want.raw_b_scaled);
    if (got.raw_c_scaled !== want.raw_c_scaled)
      report("raw_c_scaled", got.raw_c_scaled, want.raw_c_scaled);
  endtask
endclass

module testbench;

  // 650 items with their stalls and drains stay well inside this limit.
  localparam int unsigned CycleLimit = 3_000_000;
  localparam int unsigned DrainCycles = 700;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid;
  logic                  in_ready;
  tgfam_pkg::in_beat_t   in_data_i;
  logic                  out_valid;
  logic                  out_ready;
  tgfam_pkg::out_beat_t  out_data_o;
  logic                  cfg_we_i;
  logic [tgfam_pkg::CfgIdxBits-1:0]  cfg_idx_i;
  logic [tgfam_pkg::CfgDataBits-1:0] cfg_data_i;

  axis_scoreboard force_board;
  int unsigned    cycle_count;
  // While set, neither side idles: a stretch of back-to-back beats.
  bit             no_idle;

  tri_gauge_force_axis_mapper u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data_i  (in_data_i),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    force_board = new();
    rst_ni     = 1'b0;
    in_valid   = 1'b0;
    in_data_i  = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = tgfam_pkg::RegFullRange;
    cfg_data_i = '0;
    no_idle    = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // The cycle counter guards against a hung block.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // Unless no_idle is set, the receiver stalls about 9 percent of the time.
  // Outputs are sampled at the edge, so checks see exactly what was presented.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) force_board.check_result(out_data_o);
      out_ready <= no_idle || ($urandom_range(99) >= 9);
    end
  end

  // Registers are written only while nothing is in flight.
  task automatic write_reg(logic [tgfam_pkg::CfgIdxBits-1:0] idx,
                           logic [tgfam_pkg::CfgDataBits-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == tgfam_pkg::RegFullRange) force_board.full_range = value[23:0];
    else force_board.deadzone = value[14:0];
    @(posedge clk_i);
  endtask

  // Offers one beat, holding it until it is taken; the prediction is made at
  // the accepting edge. Valid stays high after the beat so that the next beat
  // can follow at once; an idle cycle or a drain drops it.
  task automatic send_beat(tgfam_pkg::in_beat_t beat);
    while (!no_idle && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    in_data_i <= beat;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    force_board.note_input(beat);
  endtask

  // Stops offering beats and waits until every expected result has come.
  task automatic wait_empty();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (force_board.pending_beats.size() != 0) @(posedge clk_i);
  endtask

  task automatic drain();
    wait_empty();
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Builds a beat from three deviations over random baselines, keeping every
  // sample and baseline inside the 24-bit range.
  function automatic tgfam_pkg::in_beat_t from_deviations(int da, int db, int dc);
    tgfam_pkg::in_beat_t beat;
    int base;
    int devs[3];
    logic signed [23:0] s[3];
    logic signed [23:0] b[3];
    devs = '{da, db, dc};
    for (int k = 0; k < 3; k++) begin
      base = $signed(24'($urandom));
      if (base + devs[k] > 8388607 || base + devs[k] < -8388608) base = -devs[k] / 2;
      b[k] = 24'(base);
      s[k] = 24'(base + devs[k]);
    end
    beat.gauge_a_sample = s[0]; beat.gauge_b_sample = s[1]; beat.gauge_c_sample = s[2];
    beat.gauge_a_baseline = b[0]; beat.gauge_b_baseline = b[1];
    beat.gauge_c_baseline = b[2];
    return beat;
  endfunction

  function automatic tgfam_pkg::in_beat_t random_beat();
    tgfam_pkg::in_beat_t beat;
    int span;
    int sel;
    sel = $urandom_range(99);
    // Mostly deviations near the configured range, so the deadzone edge and the
    // clamp both see traffic; a tenth are small, the rest raw random words.
    if (sel < 70) begin
      span = int'(force_board.full_range) * 2 + 4;
      if (span > 8000000) span = 8000000;
      beat = from_deviations($urandom_range(2 * span) - span,
                             $urandom_range(2 * span) - span,
                             $urandom_range(2 * span) - span);
    end else if (sel < 80) begin
      span = int'(force_board.full_range) / 8 + 2;
      beat = from_deviations($urandom_range(2 * span) - span,
                             $urandom_range(2 * span) - span,
                             $urandom_range(2 * span) - span);
    end else begin
      beat = tgfam_pkg::in_beat_t'(144'({$urandom, $urandom, $urandom, $urandom,
                                         $urandom}));
    end
    return beat;
  endfunction

  initial begin
    tgfam_pkg::in_beat_t beat;
    int unsigned ranges[5];
    int unsigned zones[5];
    @(posedge rst_ni);
    @(posedge clk_i);

    // Directed part at reset settings.
    send_beat('0);
    send_beat(from_deviations(0, 0, 0));
    beat = '{24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 24'sh800000};
    send_beat(beat);
    beat = '{24'sh800000, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF};
    send_beat(beat);
    send_beat(from_deviations(65536, 0, 0));
    send_beat(from_deviations(0, -65536, 65536));
    send_beat(from_deviations(-65536, -65536, -65536));
    send_beat(from_deviations(1000, 1000, 1000));
    send_beat(from_deviations(0, -2000, 2000));
    send_beat(from_deviations(-3000, 0, 0));
    send_beat('1);
    drain();

    // Zero deadzone with zero vector; zero full range acts as one.
    write_reg(tgfam_pkg::RegDeadzone, 0);
    send_beat(from_deviations(5, 5, 5));
    send_beat(from_deviations(0, 0, 0));
    drain();
    write_reg(tgfam_pkg::RegFullRange, 0);
    send_beat(from_deviations(1, -1, 0));
    send_beat(from_deviations(-1, 0, 1));
    drain();
    // Vector length exactly on the deadzone edge: pure Y with fy = dz.
    write_reg(tgfam_pkg::RegFullRange, 32768);
    write_reg(tgfam_pkg::RegDeadzone, 1000);
    send_beat(from_deviations(-1000, 0, 0));
    send_beat(from_deviations(-1001, 0, 0));
    send_beat(from_deviations(-999, 0, 0));
    drain();
    write_reg(tgfam_pkg::RegDeadzone, 32767);
    send_beat(from_deviations(-32768, 0, 0));
    send_beat(from_deviations(40000, -40000, 40000));
    drain();

    ranges = '{1, 65536, 24'hFFFFFF, 300, 1000000};
    zones  = '{1638, 0, 32767, 20000, 5};
    for (int phase = 0; phase < 5; phase++) begin
      write_reg(tgfam_pkg::RegFullRange, tgfam_pkg::CfgDataBits'(ranges[phase]));
      write_reg(tgfam_pkg::RegDeadzone, tgfam_pkg::CfgDataBits'(zones[phase]));
      for (int n = 0; n < 126; n++) begin
        no_idle = (phase == 2 && n >= 30 && n < 70);
        send_beat(random_beat());
        // Once per phase the sender waits for the block to empty.
        if (n == 60) wait_empty();
      end
      no_idle = 1'b0;
      drain();
    end

    if (force_board.mismatches == 0 && force_board.pending_beats.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

>>> files.f
hdl/tgfam_pkg.sv
hdl/tgfam_front.sv
hdl/tgfam_divider.sv
hdl/tgfam_back.sv
hdl/tri_gauge_force_axis_mapper.sv
verif/testbench.sv
